>>> rtl/core/chunked_sparse_tile_store_core_macros.svh
// Assertion shorthands for the tile store checker.
`ifndef CHUNKED_SPARSE_TILE_STORE_CORE_MACROS_SVH
`define CHUNKED_SPARSE_TILE_STORE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CSTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CSTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/csts_pkg.sv
package csts_pkg;

	localparam int COORD_W        = 16;
	localparam int VALUE_W        = 16;
	localparam int CHUNK_DIM_DEF  = 16;
	localparam int MAX_CHUNKS_DEF = 16;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	function automatic int flog2(input int v);
		int r;
		begin
			r = 0;
			for (int i = 1; i < 31; i++) begin
				if ((1 << i) <= v) begin
					r = i;
				end
			end
			return r;
		end
	endfunction

	// signed chunk coordinate width: floor(32767 / dim) plus a sign bit
	function automatic int chunk_coord_w(input int dim);
		return COORD_W - flog2(dim);
	endfunction

	function automatic int slot_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	typedef struct packed {
		logic hit;
		logic full;
	} tag_stat_t;

endpackage

>>> rtl/core/csts_req_if.sv
interface csts_req_if;
	import csts_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic signed [COORD_W-1:0] tile_x;
	logic signed [COORD_W-1:0] tile_y;
	logic signed [VALUE_W-1:0] tile_value;

	modport source (output valid, mode, tile_x, tile_y, tile_value, input ready);
	modport sink   (input valid, mode, tile_x, tile_y, tile_value, output ready);

endinterface

>>> rtl/core/csts_rsp_if.sv
interface csts_rsp_if;
	import csts_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic                      chunk_found;
	logic                      table_full;

	modport source (output valid, read_value, chunk_found, table_full, input ready);
	modport sink   (input valid, read_value, chunk_found, table_full, output ready);

endinterface

>>> rtl/core/chunked_sparse_tile_store_core.sv
// Sparse tile store over signed 16-bit (x, y) coordinates, kept in square chunks.
// req (sink): mode (0 write, 1 read), tile_x, tile_y, tile_value.
// rsp (source): read_value, chunk_found, table_full; one transaction per request.
// Chunk tags sit in a register table compared in parallel; tiles sit in one
// single-port synchronous RAM of MAX_CHUNKS * CHUNK_DIM^2 words.
// A request steps through SPLIT, OFFS, TAG, ADDR, MEM and DONE; rsp is registered from DONE.
// The block holds one request at a time and takes no new one until the last has left DONE;
// its pass runs through the coordinate split (two multiply stages), tag compare and the RAM access.
// The next request is taken while the previous response is still held on rsp.
// A write to an absent chunk takes the next free slot; with all slots used it is
// dropped and table_full is raised. A read of an absent chunk returns 0.
// Reset: tag table emptied at once, then a clearing pass zeroes the tile RAM,
// one word a cycle over all MAX_CHUNKS * CHUNK_DIM^2 words, with req.ready low.
// Receiver stall: rsp holds its transaction until taken; a finished request waits
// in its last step, and no new request is taken meanwhile.
module chunked_sparse_tile_store_core #(
	parameter int CHUNK_DIM  = csts_pkg::CHUNK_DIM_DEF,
	parameter int MAX_CHUNKS = csts_pkg::MAX_CHUNKS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	csts_req_if.sink   req,
	csts_rsp_if.source rsp
);
	import csts_pkg::*;

	localparam int CW    = chunk_coord_w(CHUNK_DIM);
	localparam int OW    = $clog2(CHUNK_DIM);
	localparam int TW    = 2 * CW;
	localparam int CT    = CHUNK_DIM * CHUNK_DIM;
	localparam int IW    = $clog2(CT);
	localparam int TOTAL = MAX_CHUNKS * CT;
	localparam int AW    = $clog2(TOTAL);
	localparam int SW    = slot_w(MAX_CHUNKS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SPLIT = 3'd2;
	localparam logic [2:0] ST_OFFS  = 3'd3;
	localparam logic [2:0] ST_TAG   = 3'd4;
	localparam logic [2:0] ST_ADDR  = 3'd5;
	localparam logic [2:0] ST_MEM   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]                state_q;
	logic [2:0]                state_d;
	logic [AW-1:0]             clr_q;
	logic                      mode_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [VALUE_W-1:0] val_q;
	logic signed [CW-1:0]      cx;
	logic signed [CW-1:0]      cy;
	logic [OW-1:0]             ox;
	logic [OW-1:0]             oy;
	logic [IW-1:0]             idx_q;
	tag_stat_t                 stat;
	logic [SW-1:0]             hit_slot;
	logic [SW-1:0]             next_slot;
	logic                      alloc;
	logic [SW-1:0]             slot_q;
	logic                      found_q;
	logic                      full_q;
	logic                      we_q;
	logic                      rd_q;
	logic                      mem_we;
	logic [AW-1:0]             mem_addr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic signed [VALUE_W-1:0] mem_rdata;
	logic                      accept;
	logic                      out_free;
	logic                      out_load;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_found_q;
	logic                      out_full_q;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign out_load  = (state_q == ST_DONE) && out_free;
	assign alloc     = (state_q == ST_ADDR) && (mode_q == MODE_WRITE) && !stat.hit
		&& !stat.full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(TOTAL - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: state_d = ST_OFFS;
			ST_OFFS:  state_d = ST_TAG;
			ST_TAG:   state_d = ST_ADDR;
			ST_ADDR:  state_d = ST_MEM;
			ST_MEM:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			x_q    <= req.tile_x;
			y_q    <= req.tile_y;
			val_q  <= req.tile_value;
		end
		idx_q <= IW'(oy * CHUNK_DIM + ox);
		if (state_q == ST_ADDR) begin
			slot_q  <= stat.hit ? hit_slot : next_slot;
			found_q <= stat.hit;
			full_q  <= (mode_q == MODE_WRITE) && !stat.hit && stat.full;
			we_q    <= (mode_q == MODE_WRITE) && (stat.hit || !stat.full);
			rd_q    <= (mode_q == MODE_READ) && stat.hit;
		end
		if (out_load) begin
			out_value_q <= rd_q ? mem_rdata : '0;
			out_found_q <= found_q;
			out_full_q  <= full_q;
		end
	end

	csts_split #(.CHUNK_DIM(CHUNK_DIM)) u_split_x (
		.clk    (clk),
		.coord  (x_q),
		.chunk  (cx),
		.offset (ox)
	);

	csts_split #(.CHUNK_DIM(CHUNK_DIM)) u_split_y (
		.clk    (clk),
		.coord  (y_q),
		.chunk  (cy),
		.offset (oy)
	);

	csts_tag #(.MAX_CHUNKS(MAX_CHUNKS), .TAG_W(TW)) u_tag (
		.clk       (clk),
		.arst_n    (arst_n),
		.alloc     (alloc),
		.tag       ({cx, cy}),
		.stat      (stat),
		.hit_slot  (hit_slot),
		.next_slot (next_slot)
	);

	assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_MEM) && we_q);
	assign mem_addr  = (state_q == ST_CLEAR) ? clr_q : AW'(slot_q * CT + idx_q);
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : val_q;

	csts_tile_mem #(.DEPTH(TOTAL)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_value_q;
	assign rsp.chunk_found = out_found_q;
	assign rsp.table_full  = out_full_q;

endmodule

>>> rtl/core/csts_split.sv
module csts_split #(
	parameter int CHUNK_DIM = csts_pkg::CHUNK_DIM_DEF
) (
	input  logic                                                   clk,
	input  logic signed [csts_pkg::COORD_W-1:0]                    coord,
	output logic signed [csts_pkg::chunk_coord_w(CHUNK_DIM)-1:0]   chunk,
	output logic        [$clog2(CHUNK_DIM)-1:0]                    offset
);
	import csts_pkg::*;

	localparam int MW    = COORD_W - 1;
	localparam int FL    = flog2(CHUNK_DIM);
	localparam int OW    = $clog2(CHUNK_DIM);
	localparam int SH    = MW + OW;
	localparam int RW    = MW + 2;
	localparam int PW    = MW + RW;
	localparam int QW    = MW - FL;
	localparam int CW    = QW + 1;
	localparam int RECIP = ((1 << SH) + CHUNK_DIM - 1) / CHUNK_DIM;
	localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

	logic [MW-1:0]        mag;
	logic [PW-1:0]        prod;
	logic                 neg_s1;
	logic [MW-1:0]        mag_s1;
	logic [QW-1:0]        quo_s1;
	logic [MW-1:0]        rem;
	logic [OW-1:0]        rem_lo;
	logic signed [CW-1:0] chunk_s2;
	logic [OW-1:0]        offset_s2;

	// negative c: -c-1 is the bitwise inverse
	assign mag  = coord[MW] ? ~coord[MW-1:0] : coord[MW-1:0];
	assign prod = PW'(mag) * PW'(RECIP_C);

	always_ff @(posedge clk) begin
		neg_s1 <= coord[MW];
		mag_s1 <= mag;
		quo_s1 <= prod[SH +: QW];
	end

	assign rem    = mag_s1 - MW'(quo_s1 * CHUNK_DIM);
	assign rem_lo = rem[OW-1:0];

	always_ff @(posedge clk) begin
		chunk_s2  <= neg_s1 ? ~{1'b0, quo_s1} : {1'b0, quo_s1};
		offset_s2 <= neg_s1 ? OW'(CHUNK_DIM - 1) - rem_lo : rem_lo;
	end

	assign chunk  = chunk_s2;
	assign offset = offset_s2;

endmodule

>>> rtl/core/csts_tag.sv
module csts_tag #(
	parameter int MAX_CHUNKS = csts_pkg::MAX_CHUNKS_DEF,
	parameter int TAG_W      = 24
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     alloc,
	input  logic [TAG_W-1:0]                         tag,
	output csts_pkg::tag_stat_t                      stat,
	output logic [csts_pkg::slot_w(MAX_CHUNKS)-1:0]  hit_slot,
	output logic [csts_pkg::slot_w(MAX_CHUNKS)-1:0]  next_slot
);
	import csts_pkg::*;

	localparam int SW = slot_w(MAX_CHUNKS);
	localparam int NW = $clog2(MAX_CHUNKS + 1);

	logic [TAG_W-1:0]      slot_tag_q [MAX_CHUNKS];
	logic [NW-1:0]         used_q;
	logic [MAX_CHUNKS-1:0] match_q;

	always_ff @(posedge clk) begin
		if (alloc) begin
			slot_tag_q[used_q[SW-1:0]] <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (alloc) begin
			used_q <= used_q + 1'b1;
		end
	end

	// slots fill in order, so slot i is live iff i < used
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			match_q[i] <= (NW'(i) < used_q) && (slot_tag_q[i] == tag);
		end
	end

	// tags are unique, at most one match
	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			if (match_q[i]) begin
				hit_slot = hit_slot | SW'(i);
			end
		end
	end

	assign stat.hit  = |match_q;
	assign stat.full = (used_q == NW'(MAX_CHUNKS));
	assign next_slot = used_q[SW-1:0];

endmodule

>>> rtl/core/csts_tile_mem.sv
module csts_tile_mem #(
	parameter int DEPTH = csts_pkg::MAX_CHUNKS_DEF * csts_pkg::CHUNK_DIM_DEF
		* csts_pkg::CHUNK_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(DEPTH)-1:0]            addr,
	input  logic signed [csts_pkg::VALUE_W-1:0] wdata,
	output logic signed [csts_pkg::VALUE_W-1:0] rdata
);
	import csts_pkg::*;

	logic signed [VALUE_W-1:0] mem [DEPTH];
	logic signed [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/csts_checker.sv
`include "chunked_sparse_tile_store_core_macros.svh"

module csts_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [csts_pkg::VALUE_W-1:0] out_read_value,
	input logic                                out_chunk_found,
	input logic                                out_table_full
);
	import csts_pkg::*;

	`CSTS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")
	`CSTS_ASSERT_NOW(a_full_clean, out_valid && out_table_full, !out_chunk_found && (out_read_value == '0), "dropped write reports data")
	`CSTS_ASSERT_NEXT(a_rsp_held, out_valid && !out_ready, out_valid, "response withdrawn")
	`CSTS_ASSERT_NEXT(a_rsp_stable, out_valid && !out_ready, $stable(out_read_value) && $stable(out_chunk_found) && $stable(out_table_full), "response changed under stall")

endmodule

bind chunked_sparse_tile_store_core csts_checker u_csts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (req.valid),
	.in_ready        (req.ready),
	.out_valid       (rsp.valid),
	.out_ready       (rsp.ready),
	.out_read_value  (rsp.read_value),
	.out_chunk_found (rsp.chunk_found),
	.out_table_full  (rsp.table_full)
);

>>> verif/tile_store_checker.sv
`timescale 1ns / 1ps

module tile_store_checker #(
	parameter int CHUNK_DIM  = csts_pkg::CHUNK_DIM_DEF,
	parameter int MAX_CHUNKS = csts_pkg::MAX_CHUNKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	csts_req_if  req,
	csts_rsp_if  rsp,
	output int   failures,
	output int   pending
);
	import csts_pkg::*;

	localparam int TILES_PER_CHUNK = CHUNK_DIM * CHUNK_DIM;

	typedef struct {
		logic signed [VALUE_W-1:0] read_value;
		logic                      chunk_found;
		logic                      table_full;
	} tile_reply_t;

	logic [COORD_W-1:0]        slot_cx   [MAX_CHUNKS];
	logic [COORD_W-1:0]        slot_cy   [MAX_CHUNKS];
	bit                        slot_live [MAX_CHUNKS];
	int                        slots_taken;
	logic signed [VALUE_W-1:0] tile_ram  [MAX_CHUNKS * TILES_PER_CHUNK];
	tile_reply_t               expected_replies [$];

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		failures++;
	endtask

	// floor division, so negative coordinates fall in the chunk below
	function automatic void floor_split(input int c, output int chunk, output int off);
		int m;
		if (c >= 0) begin
			chunk = c / CHUNK_DIM;
			off   = c % CHUNK_DIM;
		end else begin
			m     = -c - 1;
			chunk = -(m / CHUNK_DIM) - 1;
			off   = CHUNK_DIM - 1 - (m % CHUNK_DIM);
		end
	endfunction

	function automatic tile_reply_t apply_tile_access(
		input logic                      mode,
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input logic signed [VALUE_W-1:0] value
	);
		int          cx, cy, ox, oy, slot, base;
		bit          hit;
		tile_reply_t reply;
		floor_split(int'(x), cx, ox);
		floor_split(int'(y), cy, oy);
		reply = '{read_value: '0, chunk_found: 1'b0, table_full: 1'b0};
		hit   = 0;
		slot  = 0;
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			if (!hit && slot_live[i] && slot_cx[i] == cx[COORD_W-1:0]
					&& slot_cy[i] == cy[COORD_W-1:0]) begin
				hit  = 1;
				slot = i;
			end
		end
		if (mode == MODE_READ) begin
			if (hit)
				reply.read_value = tile_ram[slot * TILES_PER_CHUNK + oy * CHUNK_DIM + ox];
		end else if (hit) begin
			tile_ram[slot * TILES_PER_CHUNK + oy * CHUNK_DIM + ox] = value;
		end else if (slots_taken < MAX_CHUNKS) begin
			slot            = slots_taken;
			slots_taken++;
			slot_live[slot] = 1;
			slot_cx[slot]   = cx[COORD_W-1:0];
			slot_cy[slot]   = cy[COORD_W-1:0];
			base            = slot * TILES_PER_CHUNK;
			for (int j = 0; j < TILES_PER_CHUNK; j++)
				tile_ram[base + j] = '0;
			tile_ram[base + oy * CHUNK_DIM + ox] = value;
		end else begin
			reply.table_full = 1'b1;
		end
		reply.chunk_found = hit;
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tile_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHUNKS; i++)
				slot_live[i] = 0;
			for (int j = 0; j < MAX_CHUNKS * TILES_PER_CHUNK; j++)
				tile_ram[j] = '0;
			slots_taken = 0;
			expected_replies.delete();
		end else begin
			// retire first: a response never belongs to a request taken at the same edge
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("transaction with nothing outstanding, value %0d",
						rsp.read_value));
				end else begin
					want = expected_replies.pop_front();
					if (rsp.read_value !== want.read_value)
						report_mismatch($sformatf("read_value got %0d expected %0d",
							rsp.read_value, want.read_value));
					if (rsp.chunk_found !== want.chunk_found)
						report_mismatch($sformatf("chunk_found got %b expected %b",
							rsp.chunk_found, want.chunk_found));
					if (rsp.table_full !== want.table_full)
						report_mismatch($sformatf("table_full got %b expected %b",
							rsp.table_full, want.table_full));
				end
			end
			if (req.valid && req.ready)
				expected_replies.push_back(apply_tile_access(req.mode, req.tile_x,
					req.tile_y, req.tile_value));
		end
		pending <= expected_replies.size();
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import csts_pkg::*;

	localparam int CHUNK_DIM   = CHUNK_DIM_DEF;
	localparam int MAX_CHUNKS  = MAX_CHUNKS_DEF;
	localparam int OFF_W       = $clog2(CHUNK_DIM);
	localparam int PHASE_ITEMS = 545;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RECENT_MAX  = 32;

	logic clk = 1'b0;
	logic arst_n;

	csts_req_if req();
	csts_rsp_if rsp();

	int failures;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_wanted;
	bit hold_done;
	int hold_left;
	int cycles;

	logic [COORD_W-1:0] hot_x [$];
	logic [COORD_W-1:0] hot_y [$];
	logic [COORD_W-1:0] recent_x [$];
	logic [COORD_W-1:0] recent_y [$];

	always #6 clk = ~clk;

	chunked_sparse_tile_store_core #(
		.CHUNK_DIM  (CHUNK_DIM),
		.MAX_CHUNKS (MAX_CHUNKS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	tile_store_checker #(
		.CHUNK_DIM  (CHUNK_DIM),
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.failures (failures),
		.pending  (pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// response side: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_wanted && !hold_done) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input logic mode, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid      <= 1'b1;
		req.mode       <= mode;
		req.tile_x     <= x;
		req.tile_y     <= y;
		req.tile_value <= value;
		if (mode == MODE_WRITE) begin
			recent_x.push_back(x);
			recent_y.push_back(y);
			if (recent_x.size() > RECENT_MAX) begin
				void'(recent_x.pop_front());
				void'(recent_y.pop_front());
			end
		end
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic directed(input logic mode, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [VALUE_W-1:0] value);
		hot_x.push_back(x);
		hot_y.push_back(y);
		send_item(mode, x, y, value);
	endtask

	// mostly traffic into known chunks, some read-back of recent writes, some noise
	task automatic random_item();
		int                 r, k;
		logic               m;
		logic [COORD_W-1:0] x, y;
		r = $urandom_range(99);
		if (r < 10) begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
			m = 1'($urandom_range(1));
		end else if (r < 35 && recent_x.size() > 0) begin
			k = $urandom_range(recent_x.size() - 1);
			x = recent_x[k];
			y = recent_y[k];
			m = MODE_READ;
		end else begin
			k = $urandom_range(hot_x.size() - 1);
			x = hot_x[k];
			y = hot_y[k];
			x[OFF_W-1:0] = OFF_W'($urandom_range(CHUNK_DIM - 1));
			y[OFF_W-1:0] = OFF_W'($urandom_range(CHUNK_DIM - 1));
			m = (r < 70) ? MODE_WRITE : MODE_READ;
		end
		send_item(m, x, y, VALUE_W'($urandom));
	endtask

	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.mode       = MODE_WRITE;
		req.tile_x     = '0;
		req.tile_y     = '0;
		req.tile_value = '0;
		rsp.ready      = 1'b0;
		send_idle_pct  = 24;
		recv_idle_pct  = 56;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed(MODE_WRITE, 16'sh8000, 16'sh8000, 16'sh8000);
		directed(MODE_READ,  16'sh8000, 16'sh8000, 16'sh0000);
		directed(MODE_WRITE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		directed(MODE_READ,  16'sh7fff, 16'sh7fff, 16'shffff);
		directed(MODE_READ,  16'sd32752, 16'sd32752, 16'sh0000);
		directed(MODE_READ,  16'sd0, 16'sd0, 16'sh1111);
		directed(MODE_WRITE, -16'sd1, -16'sd1, 16'sh5a5a);
		directed(MODE_READ,  -16'sd16, -16'sd16, 16'sh0000);
		directed(MODE_WRITE, -16'sd1, -16'sd1, 16'sh1234);
		directed(MODE_READ,  -16'sd1, -16'sd1, 16'sh0000);
		directed(MODE_WRITE, 16'sd0, -16'sd1, 16'shffff);
		directed(MODE_WRITE, -16'sd17, 16'sd16, 16'sh7fff);
		directed(MODE_READ,  16'sd15, -16'sd16, 16'sh0000);
		// fill the remaining slots, then hit the full table
		for (int k = 1; k <= MAX_CHUNKS - 5; k++)
			directed(MODE_WRITE, 16'(k * 1000), 16'(-k * 777), VALUE_W'($urandom));
		directed(MODE_WRITE, 16'sd300, 16'sd300, 16'sh4321);
		directed(MODE_READ,  16'sd300, 16'sd300, 16'sh0000);
		directed(MODE_WRITE, 16'sh8000, 16'sh8000, 16'sh0000);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_wanted   = 1;
				end
			endcase
			repeat (PHASE_ITEMS) random_item();
		end

		req.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
